// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file (shs_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SHS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Next-cycle implication.
`define SHS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// ===== design/shs_pkg.sv =====
`timescale 1ns / 1ps

package shs_pkg;

   typedef logic [31:0]      word_type;
   typedef logic [7:0][31:0] hash_type;   // index 0 is a / H0

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       shift;   // push one byte into the block window
      logic       step;    // advance the message schedule by one word
      logic [7:0] data;
   } sched_ctl_type;

   localparam logic [7:0] PAD_BYTE       = 8'h80;
   localparam logic [5:0] FILL_LAST      = 6'd63;
   localparam logic [5:0] LEN_START      = 6'd56;
   localparam logic [5:0] ROOM_LAST      = 6'd55;
   localparam logic [5:0] ROUND_LAST     = 6'd63;
   localparam logic [2:0] LAST_WORD_IDX  = 3'd7;

   localparam hash_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      round_k = k;
   endfunction

endpackage

// ===== design/shs_sched.sv =====
`timescale 1ns / 1ps

// 512-bit block window. Bytes shift in at the bottom; during compression the
// same register acts as the sliding 16-word schedule window, w[t] at the top.
module shs_sched import shs_pkg::*; (
   input  logic          clock,
   input  sched_ctl_type ctl,
   output word_type      w_cur
);

   logic [511:0] win_ff, win_in;
   word_type     w_new, s0, s1;

   always_comb begin
      s0     = rotr(win_ff[479:448], 7) ^ rotr(win_ff[479:448], 18) ^ (win_ff[479:448] >> 3);
      s1     = rotr(win_ff[63:32], 17) ^ rotr(win_ff[63:32], 19) ^ (win_ff[63:32] >> 10);
      w_new  = s1 + win_ff[223:192] + s0 + win_ff[511:480];
      win_in = win_ff;
      if (ctl.shift) begin
         win_in = {win_ff[503:0], ctl.data};
      end else if (ctl.step) begin
         win_in = {win_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign w_cur = win_ff[511:480];

endmodule

// ===== design/shs_round.sv =====
`timescale 1ns / 1ps

// One SHA-256 round on the working variables.
module shs_round import shs_pkg::*; (
   input  hash_type cur,
   input  word_type w,
   input  word_type k,
   output hash_type nxt
);

   word_type big0, big1, ch, maj, t1, t2;

   always_comb begin
      big1 = rotr(cur[4], 6) ^ rotr(cur[4], 11) ^ rotr(cur[4], 25);
      ch   = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
      t1   = cur[7] + big1 + ch + k + w;
      big0 = rotr(cur[0], 2) ^ rotr(cur[0], 13) ^ rotr(cur[0], 22);
      maj  = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
      t2   = big0 + maj;
      nxt[7] = cur[6];
      nxt[6] = cur[5];
      nxt[5] = cur[4];
      nxt[4] = cur[3] + t1;
      nxt[3] = cur[2];
      nxt[2] = cur[1];
      nxt[1] = cur[0];
      nxt[0] = t1 + t2;
   end

endmodule

// ===== design/sha256_stream_hasher_unit.sv =====
`timescale 1ns / 1ps
// Stalls: a byte is taken in the idle state; a byte that fills a block stalls the input
//   for the compression (64 rounds on the single round unit, then one chaining add).
// Message end: pad and length bytes fill up to the block edge, each block is compressed,
//   then 8 digest words, one per cycle while rsp_stall is low.
// The round unit sets the pace; no byte is taken while a block is compressed.
// Reset (synchronous, active high) loads the standard initial hash, clears counts.
module sha256_stream_hasher_unit import shs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_byte_present,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   state_type     state_ff, state_in;
   logic [5:0]    fill_ff, fill_in, fill_next;    // bytes held in the current block
   logic [54:0]   bcount_ff, bcount_in, bcount_next; // full message blocks so far
   logic [63:0]   len_ff, len_in;                 // bit length, latched at message end
   logic          pad_ff, pad_in;                 // finishing a message
   logic          first_ff, first_in;             // next pad byte is 0x80
   logic          extra_ff, extra_in;             // length goes into a further block
   logic          final_ff, final_in;             // block in flight carries the length
   logic [5:0]    round_ff, round_in;
   logic [2:0]    idx_ff, idx_in;
   hash_type      chain_ff, chain_in;
   hash_type      work_ff, work_in, work_nxt;
   word_type      w_cur;
   logic [7:0]    pad_data;
   sched_ctl_type sched_ctl;

   shs_sched u_sched (
      .clock (clock),
      .ctl   (sched_ctl),
      .w_cur (w_cur)
   );

   // the shared round unit, used once per cycle through a compression
   shs_round u_round (
      .cur (work_ff),
      .w   (w_cur),
      .k   (round_k(round_ff)),
      .nxt (work_nxt)
   );

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      bcount_in = bcount_ff;
      len_in    = len_ff;
      pad_in    = pad_ff;
      first_in  = first_ff;
      extra_in  = extra_ff;
      final_in  = final_ff;
      round_in  = round_ff;
      idx_in    = idx_ff;
      chain_in  = chain_ff;
      work_in   = work_ff;
      sched_ctl = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      fill_next   = fill_ff + {5'd0, req_byte_present};
      bcount_next = bcount_ff;
      if (req_byte_present && fill_ff == FILL_LAST) begin
         bcount_next = bcount_ff + 55'd1;
      end

      // padding stream: 0x80, zeros, then the length bytes big-endian
      if (first_ff) begin
         pad_data = PAD_BYTE;
      end else if (!extra_ff && fill_ff >= LEN_START) begin
         pad_data = 8'(len_ff >> {~fill_ff[2:0], 3'b000});
      end else begin
         pad_data = 8'h00;
      end

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_byte_present) begin
                  sched_ctl.shift = 1'b1;
                  sched_ctl.data  = req_msg_byte;
                  fill_in         = fill_next;
                  bcount_in       = bcount_next;
               end
               if (req_message_end) begin
                  len_in   = {bcount_next, fill_next, 3'b000};
                  pad_in   = 1'b1;
                  first_in = 1'b1;
                  extra_in = (fill_next > ROOM_LAST);
               end
               if (req_byte_present && fill_ff == FILL_LAST) begin
                  state_in = ST_ROUND;
                  work_in  = chain_ff;
                  round_in = '0;
               end else if (req_message_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            sched_ctl.shift = 1'b1;
            sched_ctl.data  = pad_data;
            fill_in         = fill_ff + 6'd1;
            first_in        = 1'b0;
            if (fill_ff == FILL_LAST) begin
               final_in = !extra_ff;
               extra_in = 1'b0;
               state_in = ST_ROUND;
               work_in  = chain_ff;
               round_in = '0;
            end
         end
         ST_ROUND: begin
            sched_ctl.step = 1'b1;
            work_in        = work_nxt;
            round_in       = round_ff + 6'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            if (final_ff) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LAST_WORD_IDX) begin
                  // back to the post-reset state for the next message
                  chain_in  = INIT_HASH;
                  fill_in   = '0;
                  bcount_in = '0;
                  pad_in    = 1'b0;
                  final_in  = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         bcount_ff <= '0;
         pad_ff    <= 1'b0;
         first_ff  <= 1'b0;
         extra_ff  <= 1'b0;
         final_ff  <= 1'b0;
         round_ff  <= '0;
         idx_ff    <= '0;
         chain_ff  <= INIT_HASH;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         bcount_ff <= bcount_in;
         pad_ff    <= pad_in;
         first_ff  <= first_in;
         extra_ff  <= extra_in;
         final_ff  <= final_in;
         round_ff  <= round_in;
         idx_ff    <= idx_in;
         chain_ff  <= chain_in;
      end
   end

   // working variables and latched length carry no reset
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      len_ff  <= len_in;
   end

   // digest words read straight from the chaining registers, stable while stalled
   assign rsp_digest_word = chain_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == LAST_WORD_IDX);

endmodule

// ===== design/shs_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shs_checker import shs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   logic       rsp_take;
   logic       rsp_wait;
   logic       last_ok;
   logic       seq_ante;
   logic       seq_ok;
   logic [2:0] idx_exp_ff, idx_exp_in;

   assign rsp_take   = rsp_valid && !rsp_stall;
   assign rsp_wait   = rsp_valid && rsp_stall;
   assign last_ok    = rsp_last_word == (rsp_word_index == LAST_WORD_IDX);
   assign idx_exp_in = rsp_word_index + 3'd1;
   assign seq_ante   = rsp_take && !rsp_last_word;
   assign seq_ok     = rsp_valid && (rsp_word_index == idx_exp_ff);

   always_ff @(posedge clock) begin
      idx_exp_ff <= idx_exp_in;
   end

   // no input taken while a digest is going out
   `SHS_ASSERT_NOW(a_busy_emit, clock, reset, rsp_valid, req_stall)
   // last flag marks word seven only
   `SHS_ASSERT_NOW(a_last_flag, clock, reset, rsp_valid, last_ok)
   // words follow in order without a gap
   `SHS_ASSERT_NEXT(a_word_seq, clock, reset, seq_ante, seq_ok)
   // stalled word holds
   `SHS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_digest_word))

endmodule

bind sha256_stream_hasher_unit shs_checker u_shs_checker (.*);
